>>> sv/lms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lms_pkg: shared types and codes for the localization mode sequencer
// Mode codes, command codes, register indexes and the item/state structs.
// ----------------------------------------------------------------------------
package lms_pkg;

	typedef enum logic [1:0] {
		MODE_GROUND = 2'd0,
		MODE_AERIAL = 2'd1,
		MODE_RELOC  = 2'd2,
		MODE_LOST   = 2'd3
	} mode_t;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_RESULT = 1'b1;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_LOST_THR     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEGRADED_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 2'd2;

	localparam int SCAN_W    = 16;
	localparam int ATTEMPT_W = 8;
	localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX = '1;

	localparam logic [SCAN_W-1:0]    LOST_THR_RST     = 16'd20;
	localparam logic [SCAN_W-1:0]    DEGRADED_THR_RST = 16'd5;
	localparam logic [ATTEMPT_W-1:0] MAX_ATTEMPTS_RST = 8'd3;

	typedef struct packed {
		logic [SCAN_W-1:0]    lost_threshold;
		logic [SCAN_W-1:0]    degraded_threshold;
		logic [ATTEMPT_W-1:0] max_attempts;
	} cfg_t;

	typedef struct packed {
		logic              command;
		logic              aerial;
		logic              hop_complete;
		logic              hop_abort;
		logic              gnss_ok;
		logic [SCAN_W-1:0] unassociated_scans;
		logic              reloc_accepted;
	} item_t;

	typedef struct packed {
		mode_t mode;
		logic  frozen;
		logic  takeoff_snapshot_req;
		logic  reloc_req;
		logic  reloc_mandatory;
	} result_t;

	typedef struct packed {
		mode_t                mode;
		logic                 frozen;
		logic                 prev_aerial;
		logic                 hop_consumed;
		logic                 pending_mandatory;
		logic [ATTEMPT_W-1:0] attempt_count;
	} state_t;

endpackage
`default_nettype wire

>>> sv/lms_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lms_cfg_regs: configuration register file
// Holds the two scan thresholds and the attempt limit; writes beyond the
// register list are dropped.
// ----------------------------------------------------------------------------
module lms_cfg_regs
	import lms_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SCAN_W-1:0]    cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lost_threshold     <= LOST_THR_RST;
			cfg_q.degraded_threshold <= DEGRADED_THR_RST;
			cfg_q.max_attempts       <= MAX_ATTEMPTS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LOST_THR:     cfg_q.lost_threshold     <= cfg_data;
				REG_DEGRADED_THR: cfg_q.degraded_threshold <= cfg_data;
				REG_MAX_ATTEMPTS: cfg_q.max_attempts       <= cfg_data[ATTEMPT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> sv/lms_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lms_step: next-state and result logic for one item
// Resolves a periodic update or a relocalization report against the current
// sequencer state in a single combinational pass.
// ----------------------------------------------------------------------------
module lms_step
	import lms_pkg::*;
(
	input  wire cfg_t   cfg,
	input  wire state_t cur,
	input  wire item_t  item,
	output state_t      nxt,
	output result_t     res
);

	logic [ATTEMPT_W-1:0] attempt_inc;
	logic                 takeoff;
	logic                 req;
	logic                 mand;

	assign attempt_inc = (cur.attempt_count != ATTEMPT_MAX) ?
		cur.attempt_count + 1'b1 : cur.attempt_count;

	always_comb begin
		nxt     = cur;
		takeoff = 1'b0;
		req     = 1'b0;
		mand    = 1'b0;
		if (item.command == CMD_RESULT) begin
			if (cur.mode == MODE_RELOC) begin
				if (item.reloc_accepted || !cur.pending_mandatory) begin
					nxt.mode          = MODE_GROUND;
					nxt.frozen        = 1'b0;
					nxt.attempt_count = '0;
				end else begin
					nxt.attempt_count = attempt_inc;
					if (attempt_inc >= cfg.max_attempts) begin
						nxt.mode   = MODE_LOST;
						nxt.frozen = 1'b1;
					end
				end
			end
		end else begin
			// recover from lost once grounded with a fresh association
			if (nxt.mode == MODE_LOST && !item.aerial && item.unassociated_scans == '0) begin
				nxt.mode   = MODE_GROUND;
				nxt.frozen = 1'b0;
			end
			if (item.aerial && !cur.prev_aerial) begin
				nxt.mode          = MODE_AERIAL;
				nxt.frozen        = 1'b1;
				takeoff           = 1'b1;
				nxt.hop_consumed  = 1'b0;
				nxt.attempt_count = '0;
			end
			nxt.prev_aerial = item.aerial;

			if (nxt.mode == MODE_AERIAL) begin
				if (item.hop_abort) begin
					nxt.mode   = MODE_LOST;
					nxt.frozen = 1'b1;
				end else if (item.hop_complete && !nxt.hop_consumed) begin
					nxt.hop_consumed      = 1'b1;
					nxt.mode              = MODE_RELOC;
					nxt.frozen            = 1'b1;
					req                   = 1'b1;
					mand                  = !item.gnss_ok;
					nxt.pending_mandatory = !item.gnss_ok;
				end
			end else if (nxt.mode == MODE_GROUND) begin
				if (item.unassociated_scans >= cfg.lost_threshold) begin
					nxt.mode   = MODE_LOST;
					nxt.frozen = 1'b1;
				end else if (item.unassociated_scans >= cfg.degraded_threshold) begin
					nxt.frozen = 1'b1;
				end else begin
					nxt.frozen = 1'b0;
				end
			end
		end

		res.mode                 = nxt.mode;
		res.frozen               = nxt.frozen;
		res.takeoff_snapshot_req = takeoff;
		res.reloc_req            = req;
		res.reloc_mandatory      = mand;
	end

endmodule
`default_nettype wire

>>> sv/localization_mode_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// localization_mode_sequencer: ground / aerial / relocalizing / lost sequencer
//
// Input channel (in_valid/in_ready) takes one command per beat: a periodic
// update or a relocalization result report. Output channel
// (out_valid/out_ready) returns exactly one result beat per input beat, in
// order: mode, frozen and the one-shot request flags.
// An input beat first lands in one input register, then the step logic
// resolves into the result register and the sequencer state in the same
// edge. Throughput is one beat per cycle unless the receiver stalls, set
// by the single pass of the step logic; a new beat is taken while a result
// still waits. When the receiver stalls, the result register holds and the
// input register fills; in_ready drops only when both are occupied.
// The config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready and writes the thresholds and the attempt limit; write it while idle.
// Reset returns the mode to ground with all flags and counters cleared and
// the registers at their defaults (20, 5, 3).
// ----------------------------------------------------------------------------
module localization_mode_sequencer
	import lms_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SCAN_W-1:0]    cfg_data,

	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 command,
	input  wire logic                 aerial,
	input  wire logic                 hop_complete,
	input  wire logic                 hop_abort,
	input  wire logic                 gnss_ok,
	input  wire logic [SCAN_W-1:0]    unassociated_scans,
	input  wire logic                 reloc_accepted,

	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                mode,
	output logic                      frozen,
	output logic                      takeoff_snapshot_req,
	output logic                      reloc_req,
	output logic                      reloc_mandatory
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	logic    advance;
	logic    in_fire;

	lms_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lms_step u_step (
		.cfg  (cfg),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// move stage 1 into the result register when it is free or draining
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1                  <= 1'b0;
			valid_s2                  <= 1'b0;
			state_q.mode              <= MODE_GROUND;
			state_q.frozen            <= 1'b0;
			state_q.prev_aerial       <= 1'b0;
			state_q.hop_consumed      <= 1'b0;
			state_q.pending_mandatory <= 1'b0;
			state_q.attempt_count     <= '0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.command            <= command;
			item_s1.aerial             <= aerial;
			item_s1.hop_complete       <= hop_complete;
			item_s1.hop_abort          <= hop_abort;
			item_s1.gnss_ok            <= gnss_ok;
			item_s1.unassociated_scans <= unassociated_scans;
			item_s1.reloc_accepted     <= reloc_accepted;
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid            = valid_s2;
	assign mode                 = res_s2.mode;
	assign frozen               = res_s2.frozen;
	assign takeoff_snapshot_req = res_s2.takeoff_snapshot_req;
	assign reloc_req            = res_s2.reloc_req;
	assign reloc_mandatory      = res_s2.reloc_mandatory;

	a_mand_needs_req: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reloc_mandatory |-> reloc_req)
		else $error("mandatory flag without relocalization request");

	a_req_enters_reloc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reloc_req |-> (mode == MODE_RELOC) && frozen)
		else $error("relocalization request outside relocalizing mode");

	a_takeoff_not_ground: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && takeoff_snapshot_req |-> mode != MODE_GROUND)
		else $error("takeoff snapshot reported in ground mode");

	a_lost_is_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == MODE_LOST |-> state_q.frozen)
		else $error("lost mode with map updates not frozen");

	a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> $stable(state_q))
		else $error("sequencer state changed while result stalled");

endmodule
`default_nettype wire

>>> tb/localization_mode_sequencer_tb.sv
// ----------------------------------------------------------------------------
// localization_mode_sequencer_tb: self-checking bench for the mode sequencer
// Drives updates and relocalization reports under random idling and stalls.
// A local model of the sequencer predicts mode, frozen and request flags for
// every accepted beat; each result beat is compared field by field in order.
// ----------------------------------------------------------------------------
module localization_mode_sequencer_tb
	import lms_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SCAN_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 command;
	logic                 aerial;
	logic                 hop_complete;
	logic                 hop_abort;
	logic                 gnss_ok;
	logic [SCAN_W-1:0]    unassociated_scans;
	logic                 reloc_accepted;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [1:0]           mode;
	logic                 frozen;
	logic                 takeoff_snapshot_req;
	logic                 reloc_req;
	logic                 reloc_mandatory;

	// sequencer model state and register copies
	mode_t                cur_mode;
	logic                 frozen_q;
	logic                 was_aerial;
	logic                 hop_used;
	logic                 mandatory_pending;
	logic [ATTEMPT_W-1:0] attempts;
	logic [SCAN_W-1:0]    lost_thr;
	logic [SCAN_W-1:0]    degraded_thr;
	logic [ATTEMPT_W-1:0] attempt_limit;

	result_t pending_results[$];
	int      mismatches = 0;
	int      cycle_count = 0;
	int      hold_left = 0;
	bit      idling_on = 1'b1;

	localization_mode_sequencer u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.command             (command),
		.aerial              (aerial),
		.hop_complete        (hop_complete),
		.hop_abort           (hop_abort),
		.gnss_ok             (gnss_ok),
		.unassociated_scans  (unassociated_scans),
		.reloc_accepted      (reloc_accepted),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.mode                (mode),
		.frozen              (frozen),
		.takeoff_snapshot_req(takeoff_snapshot_req),
		.reloc_req           (reloc_req),
		.reloc_mandatory     (reloc_mandatory)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: a requested hold-off wins over random stalls.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			out_ready <= !(idling_on && $urandom_range(99) < 36);
		end
	end

	function automatic result_t step_sequencer(input item_t it);
		result_t res;
		res = '0;
		if (it.command == CMD_RESULT) begin
			if (cur_mode == MODE_RELOC) begin
				if (it.reloc_accepted || !mandatory_pending) begin
					cur_mode = MODE_GROUND;
					frozen_q = 1'b0;
					attempts = '0;
				end else begin
					if (attempts != ATTEMPT_MAX)
						attempts = attempts + 1'b1;
					if (attempts >= attempt_limit) begin
						cur_mode = MODE_LOST;
						frozen_q = 1'b1;
					end
				end
			end
		end else begin
			if (cur_mode == MODE_LOST && !it.aerial && it.unassociated_scans == '0) begin
				cur_mode = MODE_GROUND;
				frozen_q = 1'b0;
			end
			if (it.aerial && !was_aerial) begin
				cur_mode = MODE_AERIAL;
				frozen_q = 1'b1;
				res.takeoff_snapshot_req = 1'b1;
				hop_used = 1'b0;
				attempts = '0;
			end
			was_aerial = it.aerial;
			if (cur_mode == MODE_AERIAL) begin
				if (it.hop_abort) begin
					cur_mode = MODE_LOST;
					frozen_q = 1'b1;
				end else if (it.hop_complete && !hop_used) begin
					hop_used = 1'b1;
					cur_mode = MODE_RELOC;
					frozen_q = 1'b1;
					res.reloc_req = 1'b1;
					res.reloc_mandatory = !it.gnss_ok;
					mandatory_pending = !it.gnss_ok;
				end
			end else if (cur_mode == MODE_GROUND) begin
				if (it.unassociated_scans >= lost_thr) begin
					cur_mode = MODE_LOST;
					frozen_q = 1'b1;
				end else begin
					frozen_q = (it.unassociated_scans >= degraded_thr);
				end
			end
		end
		res.mode = cur_mode;
		res.frozen = frozen_q;
		return res;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result beat at %0t: mode=%0d", $realtime, mode);
			end else begin
				want = pending_results.pop_front();
				if (mode !== want.mode || frozen !== want.frozen
						|| takeoff_snapshot_req !== want.takeoff_snapshot_req
						|| reloc_req !== want.reloc_req
						|| reloc_mandatory !== want.reloc_mandatory) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch %0t exp m=%0d f=%b t=%b r=%b x=%b got m=%0d f=%b t=%b r=%b x=%b",
							$realtime, want.mode, want.frozen, want.takeoff_snapshot_req,
							want.reloc_req, want.reloc_mandatory, mode, frozen,
							takeoff_snapshot_req, reloc_req, reloc_mandatory);
				end
			end
		end
	end

	task automatic send_item(input item_t it);
		while (idling_on && $urandom_range(99) < 36) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid           <= 1'b1;
		command            <= it.command;
		aerial             <= it.aerial;
		hop_complete       <= it.hop_complete;
		hop_abort          <= it.hop_abort;
		gnss_ok            <= it.gnss_ok;
		unassociated_scans <= it.unassociated_scans;
		reloc_accepted     <= it.reloc_accepted;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results.push_back(step_sequencer(it));
	endtask

	task automatic offer(input logic cmd, input logic aer, input logic hd, input logic hf,
			input logic g, input logic [SCAN_W-1:0] scans, input logic acc);
		item_t it;
		it.command = cmd;
		it.aerial = aer;
		it.hop_complete = hd;
		it.hop_abort = hf;
		it.gnss_ok = g;
		it.unassociated_scans = scans;
		it.reloc_accepted = acc;
		send_item(it);
	endtask

	// Drop valid and wait out every outstanding result plus the pipe depth.
	task automatic settle_block();
		@(negedge clk);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCAN_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_LOST_THR:     lost_thr = value;
			REG_DEGRADED_THR: degraded_thr = value;
			REG_MAX_ATTEMPTS: attempt_limit = value[ATTEMPT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_settings(input int lost, input int degraded, input int limit);
		settle_block();
		write_reg(REG_LOST_THR, lost[SCAN_W-1:0]);
		write_reg(REG_DEGRADED_THR, degraded[SCAN_W-1:0]);
		write_reg(REG_MAX_ATTEMPTS, SCAN_W'(limit[ATTEMPT_W-1:0]));
	endtask

	// Scan counts around the current thresholds, the extremes, small counts and fully random values.
	function automatic logic [SCAN_W-1:0] pick_scans();
		int unsigned sel;
		int v;
		sel = $urandom_range(9);
		v = 0;
		case (sel)
			0: v = 0;
			1: v = 65535;
			2, 3: v = int'(degraded_thr) + $urandom_range(2) - 1;
			4, 5: v = int'(lost_thr) + $urandom_range(2) - 1;
			6: v = $urandom_range(30);
			default: v = $urandom_range(65535);
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[SCAN_W-1:0];
	endfunction

	// Shape items by the predicted mode so flights run takeoff, hop, report.
	function automatic item_t random_item();
		item_t it;
		bit flying;
		flying = (cur_mode == MODE_AERIAL || cur_mode == MODE_RELOC);
		if (cur_mode == MODE_RELOC)
			it.command = ($urandom_range(99) < 70) ? CMD_RESULT : CMD_UPDATE;
		else
			it.command = ($urandom_range(99) < 12) ? CMD_RESULT : CMD_UPDATE;
		it.aerial = flying ? ($urandom_range(99) < 85) : ($urandom_range(99) < 25);
		it.hop_complete = (cur_mode == MODE_AERIAL) ? ($urandom_range(99) < 45)
			: 1'($urandom_range(1));
		it.hop_abort = ($urandom_range(99) < 8);
		it.gnss_ok = 1'($urandom_range(1));
		it.unassociated_scans = pick_scans();
		it.reloc_accepted = ($urandom_range(99) < 40);
		return it;
	endfunction

	task automatic run_random(input int count);
		repeat (count) send_item(random_item());
	endtask

	task automatic test_directed_sequences();
		apply_settings(20, 5, 3);
		offer(CMD_UPDATE, 0, 0, 0, 1, 16'd0, 0);
		offer(CMD_UPDATE, 0, 0, 0, 1, 16'd5, 0);
		offer(CMD_UPDATE, 0, 0, 0, 1, 16'd4, 0);
		offer(CMD_UPDATE, 0, 0, 0, 1, 16'd19, 0);
		// report outside relocalizing is ignored
		offer(CMD_RESULT, 0, 0, 0, 1, 16'd0, 1);
		offer(CMD_UPDATE, 1, 0, 0, 1, 16'd3, 0);
		offer(CMD_UPDATE, 1, 1, 0, 0, 16'd0, 0);
		offer(CMD_RESULT, 1, 1, 1, 1, 16'hFFFF, 0);
		offer(CMD_UPDATE, 1, 1, 0, 0, 16'd0, 0);
		offer(CMD_RESULT, 0, 0, 0, 0, 16'd0, 0);
		offer(CMD_RESULT, 0, 0, 0, 0, 16'd0, 0);
		offer(CMD_UPDATE, 0, 0, 0, 1, 16'd7, 0);
		offer(CMD_UPDATE, 0, 0, 0, 1, 16'd0, 0);
		// hop failure on the takeoff beat still reports the takeoff
		offer(CMD_UPDATE, 1, 1, 1, 1, 16'd0, 0);
		offer(CMD_UPDATE, 0, 0, 0, 1, 16'd0, 0);
		offer(CMD_UPDATE, 1, 1, 0, 1, 16'd0, 0);
		offer(CMD_RESULT, 1, 0, 0, 0, 16'd0, 0);
		offer(CMD_UPDATE, 1, 1, 0, 1, 16'd2, 0);
		offer(CMD_UPDATE, 0, 0, 0, 1, 16'hFFFF, 0);
		offer(CMD_UPDATE, 1, 0, 0, 1, 16'd0, 0);
		offer(CMD_UPDATE, 1, 1, 0, 0, 16'd0, 0);
		offer(CMD_RESULT, 1, 0, 0, 0, 16'd0, 1);
		offer(CMD_UPDATE, 1, 1, 0, 0, 16'd0, 0);
	endtask

	task automatic test_threshold_extremes();
		// zero lost threshold: recover from lost and fall back in one beat
		apply_settings(0, 0, 3);
		offer(CMD_UPDATE, 0, 0, 0, 1, 16'd0, 0);
		offer(CMD_UPDATE, 0, 0, 0, 1, 16'd0, 0);
		apply_settings(65535, 65535, 3);
		offer(CMD_UPDATE, 0, 0, 0, 1, 16'hFFFE, 0);
		offer(CMD_UPDATE, 0, 0, 0, 1, 16'hFFFF, 0);
		offer(CMD_UPDATE, 0, 0, 0, 1, 16'd0, 0);
	endtask

	task automatic test_attempt_limit();
		apply_settings(20, 5, 255);
		offer(CMD_UPDATE, 0, 0, 0, 1, 16'd0, 0);
		offer(CMD_UPDATE, 1, 0, 0, 1, 16'd0, 0);
		offer(CMD_UPDATE, 1, 1, 0, 0, 16'd0, 0);
		repeat (255) offer(CMD_RESULT, 1, 0, 0, 0, 16'd0, 0);
		// a limit of zero loses on the first mandatory rejection
		apply_settings(20, 5, 0);
		offer(CMD_UPDATE, 0, 0, 0, 1, 16'd0, 0);
		offer(CMD_UPDATE, 1, 1, 0, 0, 16'd0, 0);
		offer(CMD_RESULT, 1, 0, 0, 0, 16'd0, 0);
		apply_settings(20, 5, 1);
		offer(CMD_UPDATE, 0, 0, 0, 1, 16'd0, 0);
		offer(CMD_UPDATE, 1, 1, 0, 0, 16'd0, 0);
		offer(CMD_RESULT, 1, 0, 0, 0, 16'd0, 0);
	endtask

	task automatic test_backpressure();
		apply_settings(20, 5, 3);
		hold_left = 300;
		run_random(40);
		settle_block();
	endtask

	task automatic test_random_phases();
		int lost;
		apply_settings(20, 5, 3);
		run_random(200);
		apply_settings(65535, 0, 1);
		run_random(120);
		apply_settings(0, 65535, 255);
		run_random(100);
		apply_settings(65535, 65535, 0);
		run_random(100);
		repeat (3) begin
			lost = $urandom_range(1, 40);
			apply_settings(lost, $urandom_range(0, lost), $urandom_range(1, 6));
			run_random(150);
		end
		// long stretch with no idling on either side
		settle_block();
		idling_on = 1'b0;
		run_random(200);
		settle_block();
		idling_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_LOST_THR;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_UPDATE;
		aerial = 1'b0;
		hop_complete = 1'b0;
		hop_abort = 1'b0;
		gnss_ok = 1'b0;
		unassociated_scans = '0;
		reloc_accepted = 1'b0;
		cur_mode = MODE_GROUND;
		frozen_q = 1'b0;
		was_aerial = 1'b0;
		hop_used = 1'b0;
		mandatory_pending = 1'b0;
		attempts = '0;
		lost_thr = LOST_THR_RST;
		degraded_thr = DEGRADED_THR_RST;
		attempt_limit = MAX_ATTEMPTS_RST;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_sequences();
		test_threshold_extremes();
		test_attempt_limit();
		test_backpressure();
		test_random_phases();
		settle_block();
		repeat (10) @(posedge clk);

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
sv/lms_pkg.sv
sv/lms_cfg_regs.sv
sv/lms_step.sv
sv/localization_mode_sequencer.sv
tb/localization_mode_sequencer_tb.sv
